// ===== rtl/mer_pkg.sv =====
// mer_pkg: shared constants, enums and controller/datapath bundles for the
// midpoint ellipse rasterizer. No dependencies; used by every file in rtl/.
`default_nettype none

package mer_pkg;

    localparam int COORD_BITS = 10;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int OPA_BITS   = 2 * COORD_BITS + 2;
    localparam int PROD_BITS  = OPA_BITS + SQ_BITS;
    localparam int DEC_BITS   = 4 * COORD_BITS + 8;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_INIT1,
        ST_INIT2,
        ST_INIT3,
        ST_INIT4,
        ST_TEST1,
        ST_TEST2,
        ST_TEST3,
        ST_R1_1,
        ST_R1_2,
        ST_R1_3,
        ST_R1_4,
        ST_SW1,
        ST_SW2,
        ST_SW3,
        ST_SW4,
        ST_SW5,
        ST_SW6,
        ST_R2_1,
        ST_R2_2,
        ST_R2_3,
        ST_R2_4,
        ST_EMIT
    } ctrl_state_t;

    // multiplier operand A (wide side)
    typedef enum logic [3:0] {
        OPA_ONE,
        OPA_FOUR,
        OPA_TWELVE,
        OPA_X,
        OPA_Y,
        OPA_X2P3,
        OPA_XP1,
        OPA_T,
        OPA_YM1,
        OPA_RX,
        OPA_PROD,
        OPA_A
    } opa_sel_t;

    // multiplier operand B (narrow side)
    typedef enum logic [2:0] {
        OPB_A,
        OPB_B,
        OPB_T,
        OPB_YM1,
        OPB_RX,
        OPB_Y
    } opb_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_2,
        SH_3
    } acc_sh_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_BAD,
        RES_POINT
    } res_sel_t;

    typedef struct packed {
        logic     ld_start;
        logic     ld_rx_sq;
        logic     ld_ry_sq;
        logic     ld_hold;
        opa_sel_t opa;
        opb_sel_t opb;
        acc_op_t  acc_op;
        acc_sh_t  acc_sh;
        logic     x_inc;
        logic     y_dec;
        logic     out_load;
        res_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic rad_zero;
        logic dec_le0;
        logic bx_le_ay;
        logic y_zero;
        logic out_free;
    } dp_status_t;

    localparam dp_cmd_t CMD_NOP = '{
        ld_start: 1'b0,
        ld_rx_sq: 1'b0,
        ld_ry_sq: 1'b0,
        ld_hold:  1'b0,
        opa:      OPA_ONE,
        opb:      OPB_A,
        acc_op:   ACC_NONE,
        acc_sh:   SH_0,
        x_inc:    1'b0,
        y_dec:    1'b0,
        out_load: 1'b0,
        out_sel:  RES_NONE
    };

endpackage

`default_nettype wire

// ===== rtl/mer_datapath.sv =====
// mer_datapath: coordinates, squared radii, shared multiplier, decision
// accumulator and the result register. Depends on mer_pkg.
`default_nettype none

module mer_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [mer_pkg::COORD_BITS-1:0] radius_x,
    input  wire logic [mer_pkg::COORD_BITS-1:0] radius_y,
    input  wire mer_pkg::dp_cmd_t              cmd,
    output mer_pkg::dp_status_t                status,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [mer_pkg::COORD_BITS-1:0]     point_x,
    output logic [mer_pkg::COORD_BITS-1:0]     point_y,
    output logic                               point_valid,
    output logic                               last_point,
    output logic                               bad_radius
);
    import mer_pkg::*;

    logic [COORD_BITS-1:0] rx_tmp_reg, rx_tmp_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [COORD_BITS-1:0] y_m1;
    logic [SQ_BITS-1:0]    rx_sq_reg, rx_sq_next;
    logic [SQ_BITS-1:0]    ry_sq_reg, ry_sq_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [PROD_BITS-1:0]  hold_reg, hold_next;
    logic [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [DEC_BITS-1:0]   term;
    logic [OPA_BITS-1:0]   opa;
    logic [SQ_BITS-1:0]    opb;

    logic                  res_valid_reg, res_valid_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic                  pv_reg, pv_next;
    logic                  last_reg, last_next;
    logic                  bad_reg, bad_next;

    assign y_m1 = y_reg - COORD_BITS'(1);

    always_comb
    begin
        case (cmd.opa)
            OPA_ONE:    opa = OPA_BITS'(1);
            OPA_FOUR:   opa = OPA_BITS'(4);
            OPA_TWELVE: opa = OPA_BITS'(12);
            OPA_X:      opa = OPA_BITS'(x_reg);
            OPA_Y:      opa = OPA_BITS'(y_reg);
            OPA_X2P3:   opa = OPA_BITS'({x_reg, 1'b0}) + OPA_BITS'(3);
            OPA_XP1:    opa = OPA_BITS'(x_reg) + OPA_BITS'(1);
            OPA_T:      opa = OPA_BITS'({x_reg, 1'b1});
            OPA_YM1:    opa = OPA_BITS'(y_m1);
            OPA_RX:     opa = OPA_BITS'(rx_tmp_reg);
            OPA_PROD:   opa = prod_reg[OPA_BITS-1:0];
            OPA_A:      opa = OPA_BITS'(rx_sq_reg);
            default:    opa = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.opb)
            OPB_A:   opb = rx_sq_reg;
            OPB_B:   opb = ry_sq_reg;
            OPB_T:   opb = SQ_BITS'({x_reg, 1'b1});
            OPB_YM1: opb = SQ_BITS'(y_m1);
            OPB_RX:  opb = SQ_BITS'(rx_tmp_reg);
            OPB_Y:   opb = SQ_BITS'(y_reg);
            default: opb = '0;
        endcase
    end

    assign prod_next = PROD_BITS'(opa) * PROD_BITS'(opb);

    always_comb
    begin
        case (cmd.acc_sh)
            SH_0:    term = DEC_BITS'(prod_reg);
            SH_2:    term = DEC_BITS'(prod_reg) << 2;
            SH_3:    term = DEC_BITS'(prod_reg) << 3;
            default: term = DEC_BITS'(prod_reg);
        endcase
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: dec_next = term;
            ACC_ADD:  dec_next = dec_reg + term;
            ACC_SUB:  dec_next = dec_reg - term;
            ACC_NONE: dec_next = dec_reg;
            default:  dec_next = dec_reg;
        endcase
    end

    always_comb
    begin
        rx_tmp_next = rx_tmp_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rx_sq_next  = rx_sq_reg;
        ry_sq_next  = ry_sq_reg;
        hold_next   = hold_reg;
        if (cmd.ld_start)
        begin
            rx_tmp_next = radius_x;
            x_next      = '0;
            y_next      = radius_y;
        end
        else
        begin
            if (cmd.x_inc)
            begin
                x_next = x_reg + COORD_BITS'(1);
            end
            if (cmd.y_dec)
            begin
                y_next = y_m1;
            end
        end
        if (cmd.ld_rx_sq)
        begin
            rx_sq_next = prod_reg[SQ_BITS-1:0];
        end
        if (cmd.ld_ry_sq)
        begin
            ry_sq_next = prod_reg[SQ_BITS-1:0];
        end
        if (cmd.ld_hold)
        begin
            hold_next = prod_reg;
        end
    end

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pv_next        = pv_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
            px_next        = '0;
            py_next        = '0;
            pv_next        = 1'b0;
            last_next      = 1'b0;
            bad_next       = 1'b0;
            case (cmd.out_sel)
                RES_POINT:
                begin
                    px_next   = x_reg;
                    py_next   = y_reg;
                    pv_next   = 1'b1;
                    last_next = (y_reg == '0);
                end
                RES_BAD:
                begin
                    bad_next = 1'b1;
                end
                RES_NONE:
                begin
                    bad_next = 1'b0;
                end
                default:
                begin
                    bad_next = 1'b0;
                end
            endcase
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_tmp_reg <= rx_tmp_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rx_sq_reg  <= rx_sq_next;
        ry_sq_reg  <= ry_sq_next;
        prod_reg   <= prod_next;
        hold_reg   <= hold_next;
        dec_reg    <= dec_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pv_reg     <= pv_next;
        last_reg   <= last_next;
        bad_reg    <= bad_next;
    end

    assign status.rad_zero = (radius_x == '0) || (radius_y == '0);
    assign status.dec_le0  = (dec_reg == '0) || dec_reg[DEC_BITS-1];
    assign status.bx_le_ay = (hold_reg <= prod_reg);
    assign status.y_zero   = (y_reg == '0);
    assign status.out_free = !res_valid_reg || !res_stall;

    assign res_valid   = res_valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_valid = pv_reg;
    assign last_point  = last_reg;
    assign bad_radius  = bad_reg;

endmodule

`default_nettype wire

// ===== rtl/mer_ctrl.sv =====
// mer_ctrl: sequencer for start, region one, region switch and region two
// steps; drives mer_datapath commands. Depends on mer_pkg.
`default_nettype none

module mer_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic                 kind,
    input  wire mer_pkg::dp_status_t  status,
    output mer_pkg::dp_cmd_t          cmd
);
    import mer_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        drawing_reg, drawing_next;
    logic        region2_reg, region2_next;
    logic        inside_reg, inside_next;
    res_sel_t    emit_reg, emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            drawing_reg <= 1'b0;
            region2_reg <= 1'b0;
            inside_reg  <= 1'b0;
            emit_reg    <= RES_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            drawing_reg <= drawing_next;
            region2_reg <= region2_next;
            inside_reg  <= inside_next;
            emit_reg    <= emit_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        drawing_next = drawing_reg;
        region2_next = region2_reg;
        inside_next  = inside_reg;
        emit_next    = emit_reg;
        req_stall    = 1'b1;
        cmd          = CMD_NOP;

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (kind == KIND_START)
                    begin
                        region2_next = 1'b0;
                        if (status.rad_zero)
                        begin
                            drawing_next = 1'b0;
                            emit_next    = RES_BAD;
                            state_next   = ST_EMIT;
                        end
                        else
                        begin
                            cmd.ld_start = 1'b1;
                            drawing_next = 1'b1;
                            state_next   = ST_SQ_RX;
                        end
                    end
                    else if (!drawing_reg)
                    begin
                        emit_next  = RES_NONE;
                        state_next = ST_EMIT;
                    end
                    else if (region2_reg)
                    begin
                        state_next = ST_R2_1;
                    end
                    else
                    begin
                        state_next = ST_TEST1;
                    end
                end
            end

            // start: squares, then d = A + 4B - 4A*ry
            ST_SQ_RX:
            begin
                cmd.opa    = OPA_RX;
                cmd.opb    = OPB_RX;
                state_next = ST_SQ_RY;
            end
            ST_SQ_RY:
            begin
                cmd.ld_rx_sq = 1'b1;
                cmd.opa      = OPA_Y;
                cmd.opb      = OPB_Y;
                state_next   = ST_INIT1;
            end
            ST_INIT1:
            begin
                cmd.ld_ry_sq = 1'b1;
                cmd.opa      = OPA_ONE;
                cmd.opb      = OPB_A;
                state_next   = ST_INIT2;
            end
            ST_INIT2:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.acc_sh = SH_0;
                cmd.opa    = OPA_FOUR;
                cmd.opb    = OPB_B;
                state_next = ST_INIT3;
            end
            ST_INIT3:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_0;
                cmd.opa    = OPA_Y;
                cmd.opb    = OPB_A;
                state_next = ST_INIT4;
            end
            ST_INIT4:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.acc_sh = SH_2;
                emit_next  = RES_POINT;
                state_next = ST_EMIT;
            end

            // region test: B*x <= A*y
            ST_TEST1:
            begin
                cmd.opa    = OPA_X;
                cmd.opb    = OPB_B;
                state_next = ST_TEST2;
            end
            ST_TEST2:
            begin
                cmd.ld_hold = 1'b1;
                cmd.opa     = OPA_Y;
                cmd.opb     = OPB_A;
                state_next  = ST_TEST3;
            end
            ST_TEST3:
            begin
                if (status.bx_le_ay)
                begin
                    state_next = ST_R1_1;
                end
                else
                begin
                    region2_next = 1'b1;
                    state_next   = ST_SW1;
                end
            end

            // region one
            ST_R1_1:
            begin
                inside_next = status.dec_le0;
                cmd.opa     = OPA_X2P3;
                cmd.opb     = OPB_B;
                state_next  = ST_R1_2;
            end
            ST_R1_2:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_2;
                if (inside_reg)
                begin
                    cmd.x_inc  = 1'b1;
                    emit_next  = RES_POINT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.opa    = OPA_ONE;
                    cmd.opb    = OPB_A;
                    state_next = ST_R1_3;
                end
            end
            ST_R1_3:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_3;
                cmd.opa    = OPA_Y;
                cmd.opb    = OPB_A;
                state_next = ST_R1_4;
            end
            ST_R1_4:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.acc_sh = SH_3;
                cmd.x_inc  = 1'b1;
                cmd.y_dec  = 1'b1;
                emit_next  = RES_POINT;
                state_next = ST_EMIT;
            end

            // switch: d = B*t*t + 4A*(y-1)^2 - 4AB, t = 2x+1
            ST_SW1:
            begin
                cmd.opa    = OPA_T;
                cmd.opb    = OPB_T;
                state_next = ST_SW2;
            end
            ST_SW2:
            begin
                cmd.opa    = OPA_PROD;
                cmd.opb    = OPB_B;
                state_next = ST_SW3;
            end
            ST_SW3:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.acc_sh = SH_0;
                cmd.opa    = OPA_YM1;
                cmd.opb    = OPB_YM1;
                state_next = ST_SW4;
            end
            ST_SW4:
            begin
                cmd.opa    = OPA_PROD;
                cmd.opb    = OPB_A;
                state_next = ST_SW5;
            end
            ST_SW5:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_2;
                cmd.opa    = OPA_A;
                cmd.opb    = OPB_B;
                state_next = ST_SW6;
            end
            ST_SW6:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.acc_sh = SH_2;
                state_next = ST_R2_1;
            end

            // region two
            ST_R2_1:
            begin
                inside_next = status.dec_le0;
                cmd.opa     = OPA_TWELVE;
                cmd.opb     = OPB_A;
                state_next  = ST_R2_2;
            end
            ST_R2_2:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_0;
                cmd.opa    = OPA_Y;
                cmd.opb    = OPB_A;
                state_next = ST_R2_3;
            end
            ST_R2_3:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.acc_sh = SH_3;
                if (inside_reg)
                begin
                    cmd.opa    = OPA_XP1;
                    cmd.opb    = OPB_B;
                    state_next = ST_R2_4;
                end
                else
                begin
                    cmd.y_dec  = 1'b1;
                    emit_next  = RES_POINT;
                    state_next = ST_EMIT;
                end
            end
            ST_R2_4:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_3;
                cmd.x_inc  = 1'b1;
                cmd.y_dec  = 1'b1;
                emit_next  = RES_POINT;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = emit_reg;
                    if ((emit_reg == RES_POINT) && status.y_zero)
                    begin
                        drawing_next = 1'b0;
                        region2_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// midpoint_ellipse_rasterizer: top level, first-quadrant midpoint ellipse
// point generator. Instantiates mer_ctrl and mer_datapath; uses mer_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   request | req_valid/req_stall  | kind, radius_x, radius_y
//   result  | res_valid/res_stall  | point_x, point_y, point_valid,
//           |                      | last_point, bad_radius
//
// One request at a time; one shared 22x20 multiplier with a registered
// product serves start, region one, region switch and region two steps.
// Reset is asynchronous and returns the block to idle.
// A stalled result holds in its register; a finished request then waits.
`default_nettype none

module midpoint_ellipse_rasterizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          kind,
    input  wire logic [mer_pkg::COORD_BITS-1:0] radius_x,
    input  wire logic [mer_pkg::COORD_BITS-1:0] radius_y,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [mer_pkg::COORD_BITS-1:0]     point_x,
    output logic [mer_pkg::COORD_BITS-1:0]     point_y,
    output logic                               point_valid,
    output logic                               last_point,
    output logic                               bad_radius
);
    import mer_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .status    (status),
        .cmd       (cmd)
    );

    mer_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .radius_x    (radius_x),
        .radius_y    (radius_y),
        .cmd         (cmd),
        .status      (status),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_valid (point_valid),
        .last_point  (last_point),
        .bad_radius  (bad_radius)
    );

endmodule

`default_nettype wire
